// File: hdl/gcc_pkg.sv
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared types and constants of the Gauss code checker: controller states,
// error codes, crossing table entry layout and controller/datapath signals.
// ----------------------------------------------------------------------------
package gcc_pkg;

  // error codes reported in error_kind
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_RANGE = 3'd1;
  localparam logic [2:0] ERR_THIRD = 3'd2;
  localparam logic [2:0] ERR_TYPE  = 3'd3;
  localparam logic [2:0] ERR_SIGN  = 3'd4;

  // configuration register indexes (word index, taken from paddr[2])
  localparam logic REG_CROSSING_COUNT = 1'b0;

  // reset value of crossing_count
  localparam logic [8:0] COUNT_RESET = 9'd1;

  // crossing table entry: visit count [1:0], first type [2], first sign [3]
  typedef struct packed {
    logic       sign;
    logic       over;
    logic [1:0] visits;
  } entry_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CLEAR
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;      // capture a tuple and read its table entry
    logic check;       // check the tuple, update the table, count it
    logic clear_step;  // zero one table entry of the sweep
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last;        // the tuple in hand closes the code
    logic out_busy;    // output register full and not taken this cycle
    logic clear_done;  // this sweep step is the final one
  } status_t;

endpackage

// File: hdl/gauss_code_checker.sv
// ----------------------------------------------------------------------------
// gauss_code_checker
// Checks streams of Gauss code tuples and gives one verdict per code.
//
//   channel  direction  handshake        payload
//   in       sink       in_valid/stall   crossing_index, is_over, is_positive
//   out      source     out_valid/stall  code_valid, error_kind
//   cfg      APB slave  psel/penable     crossing_count at byte address 0
//
// Each tuple is handled in two steps: capture with table read, then check and
// table read-modify-write through the single memory port.
// After the last tuple of a code a clearing sweep zeroes the table up to the
// highest index written in that code (at most MAX_CROSSINGS entries).
// After reset the sweep covers all MAX_CROSSINGS entries before a transfer.
// A verdict waits in the output register; the next code's tuples are taken
// meanwhile, and only a second verdict stalls behind it.
// ----------------------------------------------------------------------------
module gauss_code_checker
  import gcc_pkg::*;
#(
  parameter int MAX_CROSSINGS = 256
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // tuple input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [8:0]  crossing_index,
  input  logic        is_over,
  input  logic        is_positive,
  // verdict output
  output logic        out_valid,
  input  logic        out_stall,
  output logic        code_valid,
  output logic [2:0]  error_kind
);

  logic [8:0] crossing_count;
  cmd_t       cmd;
  status_t    status;

  assign pready = 1'b1;

  // configuration register write
  always_ff @(posedge clk) begin
    if (rst) begin
      crossing_count <= COUNT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_CROSSING_COUNT)) begin
      crossing_count <= pwdata[8:0];
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CROSSING_COUNT) begin
      prdata = {23'd0, crossing_count};
    end
  end

  gcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  gcc_dp #(
    .MAX_CROSSINGS (MAX_CROSSINGS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .crossing_count (crossing_count),
    .crossing_index (crossing_index),
    .is_over        (is_over),
    .is_positive    (is_positive),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .code_valid     (code_valid),
    .error_kind     (error_kind)
  );

endmodule

// File: hdl/gcc_ctrl.sv
// ----------------------------------------------------------------------------
// gcc_ctrl
// Controller of the Gauss code checker: sequences tuple capture, the check
// and table update, and the table clearing sweep after each verdict.
// ----------------------------------------------------------------------------
module gcc_ctrl
  import gcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output cmd_t    cmd,
  output logic    in_stall
);

  state_t state;
  state_t state_next;

  // state register; reset starts with a full sweep of the table
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // a verdict waits while the previous one is still held
        if (!(status.last && status.out_busy)) begin
          cmd.check  = 1'b1;
          state_next = status.last ? ST_CLEAR : ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/gcc_dp.sv
// ----------------------------------------------------------------------------
// gcc_dp
// Datapath of the Gauss code checker: crossing table memory, tuple checks,
// tuple counter, first error, sweep pointer and the output register.
// ----------------------------------------------------------------------------
module gcc_dp
  import gcc_pkg::*;
#(
  parameter int MAX_CROSSINGS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output status_t    status,
  input  logic [8:0] crossing_count,
  input  logic [8:0] crossing_index,
  input  logic       is_over,
  input  logic       is_positive,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       code_valid,
  output logic [2:0] error_kind
);

  localparam int AW = (MAX_CROSSINGS > 1) ? $clog2(MAX_CROSSINGS) : 1;

  entry_t mem [MAX_CROSSINGS];

  logic [8:0]    idx;
  logic          over;
  logic          pos;
  entry_t        rdata;
  logic [9:0]    tuple_counter;
  logic [2:0]    first_error;
  logic [AW-1:0] clr_ptr;
  logic [AW:0]   high_mark;

  logic [8:0]    n_eff;
  logic [10:0]   cnt_inc;
  logic [AW-1:0] addr;
  logic          in_range;
  logic [2:0]    err_new;
  logic          upd_en;
  entry_t        upd_data;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;

  // effective crossing count: zero taken as one, saturated at the table depth
  always_comb begin
    if (crossing_count == 9'd0) begin
      n_eff = 9'd1;
    end else if (32'(crossing_count) > MAX_CROSSINGS) begin
      n_eff = 9'(MAX_CROSSINGS);
    end else begin
      n_eff = crossing_count;
    end
  end

  assign cnt_inc     = {1'b0, tuple_counter} + 11'd1;
  assign status.last = cnt_inc >= {1'b0, n_eff, 1'b0};
  assign in_range    = idx < n_eff;
  assign addr        = AW'(idx);

  // tuple checks; only the first error of a code counts
  always_comb begin
    err_new  = first_error;
    upd_en   = 1'b0;
    upd_data = rdata;
    if (first_error == ERR_NONE) begin
      if (!in_range) begin
        err_new = ERR_RANGE;
      end else if (rdata.visits >= 2'd2) begin
        err_new = ERR_THIRD;
      end else if (rdata.visits == 2'd1) begin
        if (rdata.over == over) begin
          err_new = ERR_TYPE;
        end else if (rdata.sign != pos) begin
          err_new = ERR_SIGN;
        end else begin
          upd_en          = 1'b1;
          upd_data.visits = 2'd2;
        end
      end else begin
        upd_en   = 1'b1;
        upd_data = '{sign: pos, over: over, visits: 2'd1};
      end
    end
  end

  // single write port: table update while checking, zero while sweeping
  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr;
    mem_wd = upd_data;
    if (cmd.check && upd_en) begin
      mem_we = 1'b1;
    end else if (cmd.clear_step) begin
      mem_we = 1'b1;
      mem_wa = clr_ptr;
      mem_wd = '0;
    end
  end

  // crossing table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.accept) begin
      rdata <= mem[AW'(crossing_index)];
    end
  end

  // tuple capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx  <= crossing_index;
      over <= is_over;
      pos  <= is_positive;
    end
  end

  assign status.clear_done = ({1'b0, clr_ptr} + {{AW{1'b0}}, 1'b1}) >= high_mark;

  // tuple counter, first error, sweep pointer and written high mark
  always_ff @(posedge clk) begin
    if (rst) begin
      tuple_counter <= '0;
      first_error   <= ERR_NONE;
      clr_ptr       <= '0;
      high_mark     <= (AW+1)'(MAX_CROSSINGS);
    end else begin
      if (cmd.check) begin
        if (status.last) begin
          tuple_counter <= '0;
          first_error   <= ERR_NONE;
        end else begin
          tuple_counter <= cnt_inc[9:0];
          first_error   <= err_new;
        end
        if (upd_en && ({1'b0, addr} >= high_mark)) begin
          high_mark <= {1'b0, addr} + {{AW{1'b0}}, 1'b1};
        end
      end
      if (cmd.clear_step) begin
        if (status.clear_done) begin
          clr_ptr   <= '0;
          high_mark <= '0;
        end else begin
          clr_ptr <= clr_ptr + {{(AW-1){1'b0}}, 1'b1};
        end
      end
    end
  end

  assign status.out_busy = out_valid && out_stall;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.check && status.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check && status.last) begin
      code_valid <= (err_new == ERR_NONE);
      error_kind <= err_new;
    end
  end

endmodule
